[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Field widths, operation and status codes, and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int MODE_W    = 2;
  localparam int IN_IDX_W  = 10;
  localparam int STATUS_W  = 3;
  localparam int OUT_IDX_W = 10;
  localparam int CNT_W     = 11;

  localparam logic [CNT_W-1:0] BLOCKS_RESET = 11'd1024;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DOUBLE  = 3'd4;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PRED,
    RD_IDX,
    RD_FIRST,
    RD_FOLLOW
  } rd_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SET,
    WR_CLR
  } wr_op_t;

  typedef enum logic [1:0] {
    PRED_KEEP,
    PRED_SUCC,
    PRED_IDX,
    PRED_ZERO
  } pred_op_t;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC,
    CNT_ZERO
  } cnt_op_t;

  typedef struct packed {
    logic                accept;
    rd_op_t              rd_op;
    wr_op_t              wr_op;
    logic                take_pred;
    logic                take_scan;
    pred_op_t            pred_op;
    cnt_op_t             cnt_op;
    logic                clear_map;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              alloc_full;
    logic              pred_in_pool;
    logic              pred_free;
    logic              scan_found;
    logic              scan_last;
    logic              succ_in_pool;
    logic              succ_same_word;
    logic              succ_same_free;
    logic              follow_first_free;
    logic              count_zero;
    logic              idx_out;
    logic              idx_used;
    logic              out_busy;
  } sts_t;

endpackage

`default_nettype wire

[rtl/bitmap_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Allocates, frees and clears fixed-size blocks tracked by a used-bit map,
// with a predicted next-free block and a live block count.
// ----------------------------------------------------------------------------
//  Channel  Signals                                      Direction
//  in       in_valid/in_stall, in_mode, in_block_index   operation in
//  out      out_valid/out_stall, out_status,             result out
//           out_granted_index, out_live_count
//  cfg      cfg_wr_en, cfg_wr_data                       pool size write
//
// One operation is in flight at a time; an allocation that misses the
// prediction runs the word-per-cycle bitmap scan through the single read
// port of the used-bit memory.
// Clear needs no pass over the memory because per-word valid bits drop at once.
// Reset is synchronous and needs no clearing pass.
// A result waits in the output register under stall while the next
// operation is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_top #(
  parameter int CAPACITY  = 1024,
  parameter int WORD_BITS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bba_pkg::CNT_W-1:0]         cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bba_pkg::MODE_W-1:0]        in_mode,
  input  wire logic [bba_pkg::IN_IDX_W-1:0]      in_block_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bba_pkg::STATUS_W-1:0]           out_status,
  output logic [bba_pkg::OUT_IDX_W-1:0]          out_granted_index,
  output logic [bba_pkg::CNT_W-1:0]              out_live_count
);

  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_mode           (in_mode),
    .in_block_index    (in_block_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_live_count    (out_live_count),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

`default_nettype wire

[rtl/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator controller
// Sequences one operation at a time: decode, bitmap reads, the word scan,
// the bitmap update and the result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bba_pkg::sts_t sts,
  output bba_pkg::cmd_t      cmd
);

  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PRED,
    S_SCAN,
    S_GRANT,
    S_FOLLOW,
    S_FREE,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.mode)
          MODE_ALLOC: begin
            if (sts.alloc_full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NO_FREE;
              state_nxt      = S_DONE;
            end else if (sts.pred_in_pool) begin
              cmd.rd_op = RD_PRED;
              state_nxt = S_PRED;
            end else begin
              cmd.rd_op = RD_FIRST;
              state_nxt = S_SCAN;
            end
          end
          MODE_FREE: begin
            if (sts.count_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
              state_nxt      = S_DONE;
            end else if (sts.idx_out) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
              state_nxt      = S_DONE;
            end else begin
              cmd.rd_op = RD_IDX;
              state_nxt = S_FREE;
            end
          end
          MODE_CLEAR: begin
            cmd.clear_map  = 1'b1;
            cmd.cnt_op     = CNT_ZERO;
            cmd.pred_op    = PRED_ZERO;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_nxt      = S_DONE;
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_nxt      = S_DONE;
          end
        endcase
      end
      S_PRED: begin
        if (sts.pred_free) begin
          cmd.take_pred = 1'b1;
          state_nxt     = S_GRANT;
        end else begin
          cmd.rd_op = RD_FIRST;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_found) begin
          cmd.take_scan = 1'b1;
          state_nxt     = S_GRANT;
        end else if (sts.scan_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NO_FREE;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_op = RD_FOLLOW;
        end
      end
      S_GRANT: begin
        cmd.wr_op      = WR_SET;
        cmd.cnt_op     = CNT_INC;
        cmd.set_status = 1'b1;
        cmd.status     = ST_OK;
        state_nxt      = S_DONE;
        if (sts.succ_in_pool) begin
          if (sts.succ_same_word) begin
            if (sts.succ_same_free) begin
              cmd.pred_op = PRED_SUCC;
            end
          end else begin
            cmd.rd_op = RD_FOLLOW;
            state_nxt = S_FOLLOW;
          end
        end
      end
      S_FOLLOW: begin
        if (sts.follow_first_free) begin
          cmd.pred_op = PRED_SUCC;
        end
        state_nxt = S_DONE;
      end
      S_FREE: begin
        cmd.set_status = 1'b1;
        state_nxt      = S_DONE;
        if (!sts.idx_used) begin
          cmd.status = ST_DOUBLE;
        end else begin
          cmd.status  = ST_OK;
          cmd.wr_op   = WR_CLR;
          cmd.pred_op = PRED_IDX;
          cmd.cnt_op  = CNT_DEC;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/bba_dp.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator datapath
// Holds the used-bit memory with per-word valid bits, the prediction, the
// live count, the pool size register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dp #(
  parameter int CAPACITY  = 1024,
  parameter int WORD_BITS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bba_pkg::CNT_W-1:0]         cfg_wr_data,
  input  wire logic [bba_pkg::MODE_W-1:0]        in_mode,
  input  wire logic [bba_pkg::IN_IDX_W-1:0]      in_block_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bba_pkg::STATUS_W-1:0]           out_status,
  output logic [bba_pkg::OUT_IDX_W-1:0]          out_granted_index,
  output logic [bba_pkg::CNT_W-1:0]              out_live_count,
  input  wire bba_pkg::cmd_t                     cmd,
  output bba_pkg::sts_t                          sts
);

  import bba_pkg::*;

  localparam int NWORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int IW     = BW + WAW;

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    vld_r;

  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [WAW-1:0]       rd_addr_r;

  logic [CNT_W-1:0]     blocks_r;
  logic [CNT_W-1:0]     count_r;
  logic [IW-1:0]        pred_r;
  logic [IW-1:0]        grant_r;
  logic [MODE_W-1:0]    mode_r;
  logic [IN_IDX_W-1:0]  idx_r;
  logic [STATUS_W-1:0]  res_status_r;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [OUT_IDX_W-1:0] out_granted_r;
  logic [CNT_W-1:0]     out_live_r;

  logic [CNT_W-1:0]     pool_n;
  logic [CNT_W-1:0]     pool_m1;
  logic [CNT_W-1:0]     last_w;
  logic [CNT_W-1:0]     n_hi;
  logic [BW-1:0]        n_bit;
  logic [IW-1:0]        idx_iw;
  logic [WORD_BITS-1:0] eff;
  logic [WORD_BITS-1:0] in_pool;
  logic [WORD_BITS-1:0] free_w;
  logic [BW-1:0]        pos;
  logic                 found;
  logic [BW-1:0]        gbit;
  logic                 rd_en;
  logic [WAW-1:0]       rd_addr;
  logic [WAW-1:0]       wr_addr;
  logic [WORD_BITS-1:0] wr_word;

  assign pool_n  = (32'(blocks_r) > CAPACITY) ? CNT_W'(CAPACITY) : blocks_r;
  assign pool_m1 = pool_n - 1'b1;
  assign last_w  = pool_m1 >> BW;
  assign n_hi    = pool_n >> BW;
  assign n_bit   = pool_n[BW-1:0];
  assign idx_iw  = IW'(idx_r);
  assign eff     = rd_vld_r ? rd_data_r : '0;
  assign gbit    = grant_r[BW-1:0];

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      in_pool[b] = (32'(rd_addr_r) < 32'(n_hi)) ||
                   ((32'(rd_addr_r) == 32'(n_hi)) && (BW'(b) < n_bit));
    end
  end

  assign free_w = ~eff & in_pool;
  assign found  = |free_w;

  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_w[b]) begin
        pos = BW'(b);
      end
    end
  end

  always_comb begin
    case (cmd.rd_op)
      RD_PRED:   rd_addr = pred_r[IW-1:BW];
      RD_IDX:    rd_addr = idx_iw[IW-1:BW];
      RD_FIRST:  rd_addr = '0;
      RD_FOLLOW: rd_addr = rd_addr_r + 1'b1;
      default:   rd_addr = rd_addr_r;
    endcase
  end

  assign rd_en = (cmd.rd_op != RD_NONE);

  always_comb begin
    if (cmd.wr_op == WR_SET) begin
      wr_addr = grant_r[IW-1:BW];
      wr_word = eff | (WORD_BITS'(1) << gbit);
    end else begin
      wr_addr = idx_iw[IW-1:BW];
      wr_word = eff & ~(WORD_BITS'(1) << idx_iw[BW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_op != WR_NONE) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.clear_map) begin
      vld_r <= '0;
    end else if (cmd.wr_op != WR_NONE) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_r    <= BLOCKS_RESET;
      count_r     <= '0;
      pred_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        blocks_r <= cfg_wr_data;
      end
      case (cmd.cnt_op)
        CNT_INC:  count_r <= count_r + 1'b1;
        CNT_DEC:  count_r <= count_r - 1'b1;
        CNT_ZERO: count_r <= '0;
        default:  count_r <= count_r;
      endcase
      case (cmd.pred_op)
        PRED_SUCC: pred_r <= grant_r + 1'b1;
        PRED_IDX:  pred_r <= idx_iw;
        PRED_ZERO: pred_r <= '0;
        default:   pred_r <= pred_r;
      endcase
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r  <= in_mode;
      idx_r   <= in_block_index;
      grant_r <= '0;
    end else if (cmd.take_pred) begin
      grant_r <= pred_r;
    end else if (cmd.take_scan) begin
      grant_r <= {rd_addr_r, pos};
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
    if (cmd.load_out) begin
      out_status_r  <= res_status_r;
      out_granted_r <= OUT_IDX_W'(grant_r);
      out_live_r    <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_r;
  assign out_live_count    = out_live_r;

  always_comb begin
    sts                   = '0;
    sts.mode              = mode_r;
    sts.alloc_full        = (count_r >= pool_n);
    sts.pred_in_pool      = (32'(pred_r) < 32'(pool_n));
    sts.pred_free         = !eff[pred_r[BW-1:0]];
    sts.scan_found        = found;
    sts.scan_last         = (32'(rd_addr_r) >= 32'(last_w));
    sts.succ_in_pool      = ((32'(grant_r) + 32'd1) < 32'(pool_n));
    sts.succ_same_word    = (gbit != {BW{1'b1}});
    sts.succ_same_free    = !eff[BW'(gbit + 1'b1)];
    sts.follow_first_free = !eff[0];
    sts.count_zero        = (count_r == '0);
    sts.idx_out           = (CNT_W'(idx_r) >= pool_n);
    sts.idx_used          = eff[idx_iw[BW-1:0]];
    sts.out_busy          = out_valid_r && out_stall;
  end

endmodule

`default_nettype wire

[rtl/bba_checker.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Port-level checks on the operation and result channels, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [bba_pkg::STATUS_W-1:0]      out_status,
  input wire logic [bba_pkg::OUT_IDX_W-1:0]     out_granted_index,
  input wire logic [bba_pkg::CNT_W-1:0]         out_live_count
);

  import bba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result was withdrawn.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("A second operation was taken while one was in progress.");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_granted_index == '0))
    else $error("Granted index is non-zero on a failed operation.");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_live_count == '0))
    else $error("Empty-pool status with a non-zero live count.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_NO_FREE) ||
                  (out_status == ST_EMPTY) || (out_status == ST_RANGE) ||
                  (out_status == ST_DOUBLE))
    else $error("Result carries an undefined status code.");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_granted_index (out_granted_index),
  .out_live_count    (out_live_count)
);

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Sends allocate, free and clear operations to the allocator and compares
// every result transfer with a behavioural prediction kept in step with each
// accepted operation. Directed tests cover the empty, full, out-of-range,
// double-free and shrunk-pool cases. Random phases then run over several pool
// sizes, one of them filling the whole capacity. Bursty input and a varying
// stall pattern on the output stress the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import bba_pkg::*;

  localparam int POOL_CAPACITY = 1024;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] granted;
    logic [CNT_W-1:0]     live;
  } alloc_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_style_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CNT_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [MODE_W-1:0]    in_mode;
  logic [IN_IDX_W-1:0]  in_block_index;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [OUT_IDX_W-1:0] out_granted_index;
  logic [CNT_W-1:0]     out_live_count;

  bit [POOL_CAPACITY-1:0] block_used;
  int unsigned            pred_block;
  int unsigned            live_blocks;
  logic [CNT_W-1:0]       pool_blocks;

  alloc_result_t expected_results[$];
  alloc_result_t due;
  int unsigned   error_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   stall_run = 0;
  stall_style_t  stall_style = STALL_NONE;

  bitmap_block_allocator_top #(
    .CAPACITY(POOL_CAPACITY),
    .WORD_BITS(64)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_block_index(in_block_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_granted_index(out_granted_index),
    .out_live_count(out_live_count)
  );

  always #2 clk = ~clk;

  function automatic int unsigned active_pool();
    return (pool_blocks > POOL_CAPACITY) ? POOL_CAPACITY : pool_blocks;
  endfunction

  function automatic alloc_result_t apply_op(logic [MODE_W-1:0] mode,
                                             logic [IN_IDX_W-1:0] idx);
    alloc_result_t res;
    int unsigned   n;
    int unsigned   g;
    int unsigned   i;
    bit            hit;
    n = active_pool();
    g = 0;
    hit = 1'b0;
    res.status = ST_OK;
    case (mode)
      MODE_ALLOC: begin
        if (live_blocks < n) begin
          if (pred_block < n && !block_used[pred_block]) begin
            g = pred_block;
            hit = 1'b1;
          end else begin
            for (i = 0; i < n && !hit; i++) begin
              if (!block_used[i]) begin
                g = i;
                hit = 1'b1;
              end
            end
          end
        end
        if (hit) begin
          block_used[g] = 1'b1;
          if (g + 1 < n && !block_used[g + 1]) pred_block = g + 1;
          live_blocks++;
        end else begin
          g = 0;
          res.status = ST_NO_FREE;
        end
      end
      MODE_FREE: begin
        if (live_blocks == 0) begin
          res.status = ST_EMPTY;
        end else if (idx >= n) begin
          res.status = ST_RANGE;
        end else if (!block_used[idx]) begin
          res.status = ST_DOUBLE;
        end else begin
          block_used[idx] = 1'b0;
          pred_block = idx;
          live_blocks--;
        end
      end
      MODE_CLEAR: begin
        block_used = '0;
        live_blocks = 0;
        pred_block = 0;
      end
      default: begin
      end
    endcase
    res.granted = g[OUT_IDX_W-1:0];
    res.live = live_blocks[CNT_W-1:0];
    return res;
  endfunction

  function automatic logic [IN_IDX_W-1:0] pick_live_block();
    int unsigned n;
    int unsigned start;
    int unsigned k;
    n = active_pool();
    if (n == 0) return IN_IDX_W'($urandom_range(0, POOL_CAPACITY - 1));
    start = $urandom_range(0, n - 1);
    for (k = 0; k < n; k++) begin
      if (block_used[(start + k) % n]) return IN_IDX_W'((start + k) % n);
    end
    return IN_IDX_W'(start);
  endfunction

  task automatic issue_op(input logic [MODE_W-1:0] mode, input logic [IN_IDX_W-1:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_block_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(apply_op(mode, idx));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_pool_size(input logic [CNT_W-1:0] blocks);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= blocks;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pool_blocks = blocks;
  endtask

  task automatic test_basic_ops();
    issue_op(MODE_FREE, 10'd0);
    issue_op(MODE_ALLOC, 10'd0);
    issue_op(MODE_ALLOC, 10'h3FF);
    issue_op(MODE_ALLOC, 10'd0);
    issue_op(MODE_FREE, 10'd1);
    issue_op(MODE_FREE, 10'd1);
    issue_op(MODE_FREE, 10'h3FF);
    issue_op(MODE_ALLOC, 10'd0);
    issue_op(MODE_ALLOC, 10'd0);
    issue_op(MODE_UNUSED, 10'h3FF);
    issue_op(MODE_CLEAR, 10'h2AA);
    settle();
  endtask

  task automatic test_pool_limits();
    write_pool_size(11'd2);
    issue_op(MODE_ALLOC, 10'd0);
    issue_op(MODE_ALLOC, 10'd0);
    issue_op(MODE_ALLOC, 10'd0);
    issue_op(MODE_FREE, 10'd2);
    issue_op(MODE_FREE, 10'h3FF);
    settle();
    write_pool_size(11'd0);
    issue_op(MODE_ALLOC, 10'd0);
    issue_op(MODE_FREE, 10'd0);
    settle();
  endtask

  task automatic test_shrunk_prediction();
    write_pool_size(11'd8);
    issue_op(MODE_CLEAR, 10'd0);
    repeat (3) issue_op(MODE_ALLOC, 10'd0);
    issue_op(MODE_FREE, 10'd0);
    issue_op(MODE_FREE, 10'd1);
    issue_op(MODE_FREE, 10'd2);
    issue_op(MODE_ALLOC, 10'd0);
    settle();
    write_pool_size(11'd2);
    issue_op(MODE_ALLOC, 10'd0);
    settle();
  endtask

  task automatic random_ops(input logic [CNT_W-1:0] blocks, input int unsigned items,
                            input int unsigned alloc_pm, input int unsigned clear_pm);
    int unsigned r;
    write_pool_size(blocks);
    repeat (items) begin
      r = $urandom_range(0, 999);
      if (r < alloc_pm)
        issue_op(MODE_ALLOC, IN_IDX_W'($urandom));
      else if (r < 950 - clear_pm)
        issue_op(MODE_FREE, pick_live_block());
      else if (r < 990 - clear_pm)
        issue_op(MODE_FREE, IN_IDX_W'($urandom));
      else if (r < 990)
        issue_op(MODE_CLEAR, IN_IDX_W'($urandom));
      else
        issue_op(MODE_UNUSED, IN_IDX_W'($urandom));
    end
    settle();
  endtask

  task automatic test_fill_to_capacity();
    random_ops(11'd2047, 1300, 900, 0);
  endtask

  task automatic test_random_pool_sizes();
    random_ops(11'd1, 60, 450, 30);
    random_ops(11'd8, 100, 550, 20);
    random_ops(11'd65, 120, 600, 10);
    random_ops(11'd1024, 60, 400, 20);
    random_ops(CNT_W'($urandom_range(2, POOL_CAPACITY)), 100, 500, 10);
    random_ops(11'd0, 20, 500, 50);
  endtask

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_style <= stall_style_t'($urandom_range(0, 3));
      stall_run <= $urandom_range(16, 160);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_style)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_HALF:   out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 8);
      STALL_TOGGLE: out_stall <= ~out_stall;
      default:      out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transfer, status %0d granted %0d live %0d", $time,
                 out_status, out_granted_index, out_live_count);
        error_count++;
      end else begin
        due = expected_results.pop_front();
        if (out_status !== due.status) begin
          $display("%0t: status expected %0d actual %0d", $time, due.status, out_status);
          error_count++;
        end
        if (out_granted_index !== due.granted) begin
          $display("%0t: granted index expected %0d actual %0d", $time, due.granted,
                   out_granted_index);
          error_count++;
        end
        if (out_live_count !== due.live) begin
          $display("%0t: live count expected %0d actual %0d", $time, due.live,
                   out_live_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_mode = MODE_ALLOC;
    in_block_index = '0;
    block_used = '0;
    pred_block = 0;
    live_blocks = 0;
    pool_blocks = BLOCKS_RESET;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    test_basic_ops();
    test_pool_limits();
    test_shrunk_prediction();
    test_fill_to_capacity();
    test_random_pool_sizes();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
